>>> rtl/fnvd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fnvd_pkg
// Shared types and sizes for the flat normal vertex dedup block.
// ----------------------------------------------------------------------------
package fnvd_pkg;

  localparam int POS_BITS       = 24;
  localparam int NORM_FRAC_BITS = 14;
  localparam int TABLE_DEPTH    = 256;
  localparam int IDX_W          = $clog2(TABLE_DEPTH);
  localparam int CNT_W          = IDX_W + 1;
  localparam int VIDX_W         = 8;
  localparam int NRM_W          = 16;
  localparam int COLOR_W        = 48;

  // Edge vectors are narrowed for very wide positions so products stay small
  localparam int DIFF_SHIFT = (POS_BITS > 30) ? POS_BITS - 30 : 0;
  localparam int DIFF_W     = POS_BITS + 1 - DIFF_SHIFT;
  localparam int CROSS_W    = 2 * DIFF_W + 1;
  localparam int MAG_W      = (CROSS_W > 31) ? CROSS_W : 31;
  localparam int MUL_W      = (DIFF_W > 31) ? DIFF_W : 31;

  localparam int ENTRY_W    = 3 * POS_BITS + 3 * NRM_W + COLOR_W;
  localparam int FIFO_DEPTH = 2;

  typedef struct packed {
    logic                       new_mesh;
    logic signed [POS_BITS-1:0] a_x;
    logic signed [POS_BITS-1:0] a_y;
    logic signed [POS_BITS-1:0] a_z;
    logic signed [POS_BITS-1:0] b_x;
    logic signed [POS_BITS-1:0] b_y;
    logic signed [POS_BITS-1:0] b_z;
    logic signed [POS_BITS-1:0] c_x;
    logic signed [POS_BITS-1:0] c_y;
    logic signed [POS_BITS-1:0] c_z;
    logic [COLOR_W-1:0]         shape_color;
  } in_item_t;

  typedef struct packed {
    logic [VIDX_W-1:0]          vertex_index;
    logic                       is_new;
    logic signed [POS_BITS-1:0] out_x;
    logic signed [POS_BITS-1:0] out_y;
    logic signed [POS_BITS-1:0] out_z;
    logic signed [NRM_W-1:0]    normal_x;
    logic signed [NRM_W-1:0]    normal_y;
    logic signed [NRM_W-1:0]    normal_z;
    logic [COLOR_W-1:0]         out_color;
    logic                       table_full;
    logic                       last_corner;
  } out_item_t;

  // Triangle with its finished face normal, queued for the table search
  typedef struct packed {
    in_item_t                item;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
  } tri_t;

endpackage
`default_nettype wire

>>> rtl/fnvd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fnvd_queue
// Short triangle queue between the normal unit and the table search.
// ----------------------------------------------------------------------------
module fnvd_queue import fnvd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  tri_t push_data,
  output logic full,
  input  logic pop,
  output tri_t pop_data,
  output logic not_empty
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int QCNT_W = $clog2(FIFO_DEPTH + 1);

  tri_t              mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full      = (count_r == QCNT_W'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rd_ptr_r];

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store request
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> rtl/fnvd_normal.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fnvd_normal
// Front end: takes a triangle and computes its flat face normal with a shared
// multiplier, a shift normalizer, a bit-serial square root and divider.
// ----------------------------------------------------------------------------
module fnvd_normal import fnvd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     push,
  output tri_t     push_data,
  input  logic     q_full
);

  typedef enum logic [8:0] {
    N_IDLE  = 9'b000000001,
    N_CROSS = 9'b000000010,
    N_ABS   = 9'b000000100,
    N_NORM  = 9'b000001000,
    N_SQ    = 9'b000010000,
    N_SQRT  = 9'b000100000,
    N_DLOAD = 9'b001000000,
    N_DIV   = 9'b010000000,
    N_PUSH  = 9'b100000000
  } nstate_t;

  localparam logic [MAG_W-1:0] MAG_HI = MAG_W'(64'd1 << 30);
  localparam logic [MAG_W-1:0] MAG_LO = MAG_W'(64'd1 << 29);

  nstate_t                      state_r, state_nxt;
  in_item_t                     item_r;
  logic signed [DIFF_W-1:0]     ab_r [3];
  logic signed [DIFF_W-1:0]     ac_r [3];
  logic signed [CROSS_W-1:0]    cr_r [3];
  logic                         neg_r [3];
  logic [MAG_W-1:0]             mag_r [3];
  logic [4:0]                   step_r;
  logic signed [2*MUL_W-1:0]    prod_r;
  logic signed [MUL_W-1:0]      mul_a, mul_b;
  logic [63:0]                  s_r, x_r, res_r, bit_r;
  logic [1:0]                   comp_r;
  logic [47:0]                  rem_r, div_r;
  logic [15:0]                  q_r;
  logic signed [NRM_W-1:0]      nrm_r [3];
  logic signed [POS_BITS:0]     dab_full [3];
  logic signed [POS_BITS:0]     dac_full [3];
  logic [MAG_W-1:0]             mx;
  logic [MAG_W-1:0]             mag_sel;
  logic                         neg_sel;
  logic [63:0]                  sq_try;
  logic                         rem_ge;
  logic [15:0]                  q_done;
  logic [15:0]                  q_sat;

  assign in_stall  = (state_r != N_IDLE);
  assign push      = (state_r == N_PUSH);
  assign push_data = '{item: item_r, nx: nrm_r[0], ny: nrm_r[1], nz: nrm_r[2]};

  // Edge vectors b-a and c-a, floored when positions are wide
  always_comb begin
    dab_full[0] = {in_data.b_x[POS_BITS-1], in_data.b_x} - {in_data.a_x[POS_BITS-1], in_data.a_x};
    dab_full[1] = {in_data.b_y[POS_BITS-1], in_data.b_y} - {in_data.a_y[POS_BITS-1], in_data.a_y};
    dab_full[2] = {in_data.b_z[POS_BITS-1], in_data.b_z} - {in_data.a_z[POS_BITS-1], in_data.a_z};
    dac_full[0] = {in_data.c_x[POS_BITS-1], in_data.c_x} - {in_data.a_x[POS_BITS-1], in_data.a_x};
    dac_full[1] = {in_data.c_y[POS_BITS-1], in_data.c_y} - {in_data.a_y[POS_BITS-1], in_data.a_y};
    dac_full[2] = {in_data.c_z[POS_BITS-1], in_data.c_z} - {in_data.a_z[POS_BITS-1], in_data.a_z};
  end

  // Select multiplier operands: cross terms, then squares
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == N_CROSS) begin
      case (step_r)
        5'd0: begin mul_a = MUL_W'(ac_r[1]); mul_b = MUL_W'(ab_r[2]); end
        5'd1: begin mul_a = MUL_W'(ac_r[2]); mul_b = MUL_W'(ab_r[1]); end
        5'd2: begin mul_a = MUL_W'(ac_r[2]); mul_b = MUL_W'(ab_r[0]); end
        5'd3: begin mul_a = MUL_W'(ac_r[0]); mul_b = MUL_W'(ab_r[2]); end
        5'd4: begin mul_a = MUL_W'(ac_r[0]); mul_b = MUL_W'(ab_r[1]); end
        5'd5: begin mul_a = MUL_W'(ac_r[1]); mul_b = MUL_W'(ab_r[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else begin
      case (step_r)
        5'd0: mul_a = MUL_W'($signed({1'b0, mag_r[0][29:0]}));
        5'd1: mul_a = MUL_W'($signed({1'b0, mag_r[1][29:0]}));
        5'd2: mul_a = MUL_W'($signed({1'b0, mag_r[2][29:0]}));
        default: mul_a = '0;
      endcase
      mul_b = mul_a;
    end
  end

  // Largest magnitude, for the normalizing shift
  always_comb begin
    mx = mag_r[0];
    if (mag_r[1] > mx) mx = mag_r[1];
    if (mag_r[2] > mx) mx = mag_r[2];
  end

  // Component under division
  always_comb begin
    case (comp_r)
      2'd0: begin mag_sel = mag_r[0]; neg_sel = neg_r[0]; end
      2'd1: begin mag_sel = mag_r[1]; neg_sel = neg_r[1]; end
      default: begin mag_sel = mag_r[2]; neg_sel = neg_r[2]; end
    endcase
  end

  assign sq_try = res_r + bit_r;
  assign rem_ge = (rem_r >= div_r);
  assign q_done = {q_r[14:0], rem_ge};
  assign q_sat  = q_done[15] ? 16'h7fff : q_done;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      N_IDLE:  if (in_valid) state_nxt = N_CROSS;
      N_CROSS: if (step_r == 5'd6) state_nxt = N_ABS;
      N_ABS: begin
        if (cr_r[0] == '0 && cr_r[1] == '0 && cr_r[2] == '0) begin
          state_nxt = N_PUSH;
        end else begin
          state_nxt = N_NORM;
        end
      end
      N_NORM:  if (mx < MAG_HI && mx >= MAG_LO) state_nxt = N_SQ;
      N_SQ:    if (step_r == 5'd3) state_nxt = N_SQRT;
      N_SQRT:  if (bit_r == '0) state_nxt = N_DLOAD;
      N_DLOAD: state_nxt = N_DIV;
      N_DIV: begin
        if (step_r == 5'd15) begin
          state_nxt = (comp_r == 2'd2) ? N_PUSH : N_DLOAD;
        end
      end
      N_PUSH:  if (!q_full) state_nxt = N_IDLE;
      default: state_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      N_IDLE: begin
        item_r <= in_data;
        step_r <= '0;
        for (int i = 0; i < 3; i++) begin
          ab_r[i] <= DIFF_W'(dab_full[i] >>> DIFF_SHIFT);
          ac_r[i] <= DIFF_W'(dac_full[i] >>> DIFF_SHIFT);
          cr_r[i] <= '0;
          nrm_r[i] <= '0;
        end
      end
      N_CROSS: begin
        step_r <= step_r + 1'b1;
        case (step_r)
          5'd1: cr_r[0] <= cr_r[0] + CROSS_W'(prod_r);
          5'd2: cr_r[0] <= cr_r[0] - CROSS_W'(prod_r);
          5'd3: cr_r[1] <= cr_r[1] + CROSS_W'(prod_r);
          5'd4: cr_r[1] <= cr_r[1] - CROSS_W'(prod_r);
          5'd5: cr_r[2] <= cr_r[2] + CROSS_W'(prod_r);
          5'd6: cr_r[2] <= cr_r[2] - CROSS_W'(prod_r);
          default: ;
        endcase
      end
      N_ABS: begin
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= cr_r[i][CROSS_W-1];
          mag_r[i] <= cr_r[i][CROSS_W-1] ? MAG_W'(CROSS_W'(-cr_r[i]))
                                         : MAG_W'(CROSS_W'(cr_r[i]));
        end
        step_r <= '0;
        s_r    <= '0;
      end
      N_NORM: begin
        // Shift all magnitudes one place until the largest sits in [2^29, 2^30)
        for (int i = 0; i < 3; i++) begin
          if (mx >= MAG_HI) begin
            mag_r[i] <= mag_r[i] >> 1;
          end else if (mx < MAG_LO) begin
            mag_r[i] <= mag_r[i] << 1;
          end
        end
        step_r <= '0;
      end
      N_SQ: begin
        step_r <= step_r + 1'b1;
        if (step_r != 5'd0) begin
          s_r <= s_r + 64'(prod_r);
        end
        x_r   <= s_r + 64'(prod_r);
        res_r <= '0;
        bit_r <= 64'd1 << 62;
        comp_r <= '0;
      end
      N_SQRT: begin
        // One result bit per cycle
        if (bit_r != '0) begin
          if (x_r >= sq_try) begin
            x_r   <= x_r - sq_try;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end
      end
      N_DLOAD: begin
        rem_r  <= (48'(mag_sel[29:0]) << NORM_FRAC_BITS) + 48'(res_r[31:1]);
        div_r  <= 48'(res_r[31:0]) << 15;
        q_r    <= '0;
        step_r <= '0;
      end
      N_DIV: begin
        // Restoring divide, one quotient bit per cycle
        if (rem_ge) begin
          rem_r <= rem_r - div_r;
        end
        div_r  <= div_r >> 1;
        q_r    <= q_done;
        step_r <= step_r + 1'b1;
        if (step_r == 5'd15) begin
          nrm_r[comp_r] <= neg_sel ? NRM_W'(-q_sat) : NRM_W'(q_sat);
          comp_r <= comp_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/fnvd_dedup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fnvd_dedup
// Back end: searches the vertex table per corner, appends misses while the table has
// room and drives the result register.
// ----------------------------------------------------------------------------
module fnvd_dedup import fnvd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  tri_t      q_data,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    D_IDLE   = 3'b001,
    D_SEARCH = 3'b010,
    D_EMIT   = 3'b100
  } dstate_t;

  dstate_t                    state_r, state_nxt;
  tri_t                       tri_r;
  logic [1:0]                 corner_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [CNT_W-1:0]           raddr_r;
  logic                       pend_r;
  logic [IDX_W-1:0]           pidx_r;
  logic [IDX_W-1:0]           idx_r;
  logic                       new_r, full_r;
  logic [ENTRY_W-1:0]         mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0]         rd_data_r;
  logic [ENTRY_W-1:0]         key;
  logic signed [POS_BITS-1:0] px, py, pz;
  logic                       hit, more, room, done, can_load;
  logic                       mem_re, mem_we;
  logic                       out_valid_r;
  out_item_t                  out_data_r;

  // Corner under search
  always_comb begin
    case (corner_r)
      2'd0: begin px = tri_r.item.a_x; py = tri_r.item.a_y; pz = tri_r.item.a_z; end
      2'd1: begin px = tri_r.item.b_x; py = tri_r.item.b_y; pz = tri_r.item.b_z; end
      default: begin px = tri_r.item.c_x; py = tri_r.item.c_y; pz = tri_r.item.c_z; end
    endcase
  end

  assign key = {px, py, pz, tri_r.nx, tri_r.ny, tri_r.nz, tri_r.item.shape_color};

  assign hit      = pend_r && (rd_data_r == key);
  assign more     = (raddr_r < cnt_r);
  assign room     = (cnt_r < CNT_W'(TABLE_DEPTH));
  assign done     = (state_r == D_SEARCH) && (hit || !more);
  assign mem_re   = (state_r == D_SEARCH) && !hit && more;
  assign mem_we   = (state_r == D_SEARCH) && !hit && !more && room;
  assign can_load = !out_valid_r || !out_stall;
  assign pop      = (state_r == D_IDLE) && q_valid;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      D_IDLE:   if (q_valid) state_nxt = D_SEARCH;
      D_SEARCH: if (done) state_nxt = D_EMIT;
      D_EMIT: begin
        if (can_load) begin
          state_nxt = (corner_r == 2'd2) ? D_IDLE : D_SEARCH;
        end
      end
      default:  state_nxt = D_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= D_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop && q_data.item.new_mesh) begin
        cnt_r <= '0;
      end else if (mem_we) begin
        cnt_r <= cnt_r + 1'b1;
      end
      pend_r <= mem_re;
      if (state_r == D_EMIT && can_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Search bookkeeping and result register
  always_ff @(posedge clk) begin
    case (state_r)
      D_IDLE: begin
        tri_r    <= q_data;
        corner_r <= '0;
        raddr_r  <= '0;
      end
      D_SEARCH: begin
        if (mem_re) begin
          raddr_r <= raddr_r + 1'b1;
          pidx_r  <= raddr_r[IDX_W-1:0];
        end
        if (hit) begin
          idx_r  <= pidx_r;
          new_r  <= 1'b0;
          full_r <= 1'b0;
        end else if (!more) begin
          idx_r  <= room ? cnt_r[IDX_W-1:0] : '0;
          new_r  <= room;
          full_r <= !room;
        end
      end
      D_EMIT: begin
        if (can_load) begin
          out_data_r.vertex_index <= VIDX_W'(idx_r);
          out_data_r.is_new       <= new_r;
          out_data_r.out_x        <= px;
          out_data_r.out_y        <= py;
          out_data_r.out_z        <= pz;
          out_data_r.normal_x     <= tri_r.nx;
          out_data_r.normal_y     <= tri_r.ny;
          out_data_r.normal_z     <= tri_r.nz;
          out_data_r.out_color    <= tri_r.item.shape_color;
          out_data_r.table_full   <= full_r;
          out_data_r.last_corner  <= (corner_r == 2'd2);
          corner_r <= corner_r + 1'b1;
          raddr_r  <= '0;
        end
      end
      default: ;
    endcase
  end

  // Vertex table: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[IDX_W-1:0]] <= key;
    end
    if (mem_re) begin
      rd_data_r <= mem[raddr_r[IDX_W-1:0]];
    end
  end

endmodule
`default_nettype wire

>>> rtl/flat_normal_vertex_dedup.sv
`timescale 1ns / 1ps
`default_nettype none
// Face normal steps: accept, cross products, absolute values, normalizing shift, squares,
//   square root, three divides, push; then per corner a table search and an emit.
// Flow: the normal unit takes a new triangle only when idle, and the queue lets it run
//   ahead of the search, which reads the table one entry a cycle via a single memory port.
// Reset: synchronous active low; empties the table count and queue, clears the result valid.
// ----------------------------------------------------------------------------
// flat_normal_vertex_dedup
// Flat face normal and vertex table deduplication, three results per triangle.
// ----------------------------------------------------------------------------
module flat_normal_vertex_dedup import fnvd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic push, q_full, pop, q_valid;
  tri_t push_data, q_data;

  // Compute face normals
  fnvd_normal u_normal (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // Hold finished triangles
  fnvd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .not_empty (q_valid)
  );

  // Search and append corners
  fnvd_dedup u_dedup (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
